>>> design/arm_disarm_safety_supervisor_assert.svh
// Assertion macros used by the checker of this block.
// Each macro expands to one labeled concurrent assertion, clocked on the rising
// edge and switched off while reset is asserted.
`ifndef ARM_DISARM_SAFETY_SUPERVISOR_ASSERT_SVH
`define ARM_DISARM_SAFETY_SUPERVISOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adss assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ADSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adss assertion failed");

`endif

>>> design/adss_pkg.sv
package adss_pkg;

  // Width of the time stamps kept and subtracted inside the block.
  localparam int TIME_W = 32;
  // Width of the time stamp field on the command channel.
  localparam int NOW_W = 32;
  localparam int FUNC_W = 3;
  localparam int CLASS_W = 2;
  localparam int THR_W = 16;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_LSB = 2;

  localparam logic [0:0] REG_HOLD_STAND = 1'd0;
  localparam logic [0:0] REG_DISARM = 1'd1;

  localparam logic [THR_W-1:0] HOLD_STAND_DEFAULT_MS = 16'd200;
  localparam logic [THR_W-1:0] DISARM_DEFAULT_MS = 16'd1000;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_TICK = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_NOTE_INTENT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ENTER_BRAIN = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ENTER_MUX = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_ARM = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_DISARM = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_LATCH_ESTOP = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_ESTOP = 3'd7;

  // Intent classes.
  localparam logic [CLASS_W-1:0] CLASS_FRESH = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_HOLD_STAND = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_DISARM_REQ = 2'd2;
  localparam logic [CLASS_W-1:0] CLASS_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [NOW_W-1:0]  now_time_ms;
    logic              config_ok;
  } cmd_t;

  typedef struct packed {
    logic               accepted;
    logic [CLASS_W-1:0] intent_class;
    logic               brain_mode;
    logic               is_armed;
    logic               estop_active;
    logic               ramp_reset;
    logic               may_enter_brain;
  } res_t;

  typedef struct packed {
    logic [THR_W-1:0] hold_stand_timeout_ms;
    logic [THR_W-1:0] disarm_timeout_ms;
  } thr_t;

endpackage

>>> design/adss_if.sv
interface adss_cmd_if import adss_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NOW_W-1:0]  now_time_ms;
  logic              config_ok;

  modport source (output valid, output func, output now_time_ms, output config_ok,
                  input ready);
  modport sink (input valid, input func, input now_time_ms, input config_ok,
                output ready);
endinterface

interface adss_res_if import adss_pkg::*;;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [CLASS_W-1:0] intent_class;
  logic               brain_mode;
  logic               is_armed;
  logic               estop_active;
  logic               ramp_reset;
  logic               may_enter_brain;

  modport source (output valid, output accepted, output intent_class, output brain_mode,
                  output is_armed, output estop_active, output ramp_reset,
                  output may_enter_brain, input ready);
  modport sink (input valid, input accepted, input intent_class, input brain_mode,
                input is_armed, input estop_active, input ramp_reset,
                input may_enter_brain, output ready);
endinterface

>>> design/adss_cfg.sv
module adss_cfg import adss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output thr_t                  thr
);

  thr_t       thr_r;
  thr_t       thr_nxt;
  logic [0:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_IDX_LSB];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    thr_nxt = thr_r;
    if (wr_en) begin
      case (reg_idx)
        REG_HOLD_STAND: thr_nxt.hold_stand_timeout_ms = pwdata[THR_W-1:0];
        REG_DISARM:     thr_nxt.disarm_timeout_ms = pwdata[THR_W-1:0];
        default:        thr_nxt = thr_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HOLD_STAND: prdata = CFG_DATA_W'(thr_r.hold_stand_timeout_ms);
      REG_DISARM:     prdata = CFG_DATA_W'(thr_r.disarm_timeout_ms);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.hold_stand_timeout_ms <= HOLD_STAND_DEFAULT_MS;
      thr_r.disarm_timeout_ms     <= DISARM_DEFAULT_MS;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  assign thr = thr_r;

endmodule

>>> design/adss_core.sv
module adss_core import adss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  thr_t thr,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_ready,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic              brain_r;
  logic              brain_nxt;
  logic              armed_r;
  logic              armed_nxt;
  logic              estop_r;
  logic              estop_nxt;
  logic [TIME_W-1:0] last_r;
  logic [TIME_W-1:0] last_nxt;
  logic              res_valid_r;
  res_t              res_r;
  res_t              res_nxt;
  logic [TIME_W-1:0] now_t;
  logic [TIME_W-1:0] stale;
  logic [CLASS_W-1:0] cls_calc;
  logic              fire;

  assign cmd_ready = !res_valid_r || res_ready;
  assign fire      = cmd_valid && cmd_ready;

  // Staleness wraps modulo the time width, like the time stamps themselves.
  assign now_t = TIME_W'(cmd.now_time_ms);
  assign stale = now_t - last_r;

  always_comb begin
    if (stale > TIME_W'(thr.disarm_timeout_ms)) begin
      cls_calc = CLASS_DISARM_REQ;
    end else if (stale > TIME_W'(thr.hold_stand_timeout_ms)) begin
      cls_calc = CLASS_HOLD_STAND;
    end else begin
      cls_calc = CLASS_FRESH;
    end
  end

  always_comb begin
    brain_nxt = brain_r;
    armed_nxt = armed_r;
    estop_nxt = estop_r;
    last_nxt  = last_r;
    res_nxt   = '0;
    res_nxt.accepted     = 1'b1;
    res_nxt.intent_class = CLASS_FRESH;
    case (cmd.func)
      FUNC_TICK: begin
        if (estop_r) begin
          armed_nxt            = 1'b0;
          res_nxt.ramp_reset   = 1'b1;
          res_nxt.intent_class = CLASS_DISARM_REQ;
        end else begin
          res_nxt.intent_class = cls_calc;
          if (cls_calc == CLASS_DISARM_REQ) begin
            armed_nxt          = 1'b0;
            res_nxt.ramp_reset = 1'b1;
          end else if (cls_calc == CLASS_HOLD_STAND && armed_r) begin
            res_nxt.ramp_reset = 1'b1;
          end
        end
      end
      FUNC_NOTE_INTENT: begin
        last_nxt = now_t;
      end
      FUNC_ENTER_BRAIN: begin
        if (!brain_r && !armed_r && !estop_r && cmd.config_ok) begin
          brain_nxt          = 1'b1;
          armed_nxt          = 1'b0;
          res_nxt.ramp_reset = 1'b1;
        end else begin
          res_nxt.accepted = 1'b0;
        end
      end
      FUNC_ENTER_MUX: begin
        brain_nxt          = 1'b0;
        armed_nxt          = 1'b0;
        res_nxt.ramp_reset = 1'b1;
      end
      FUNC_ARM: begin
        if (!brain_r || estop_r || !cmd.config_ok) begin
          armed_nxt        = 1'b0;
          res_nxt.accepted = 1'b0;
        end else begin
          armed_nxt          = 1'b1;
          last_nxt           = now_t;
          res_nxt.ramp_reset = 1'b1;
        end
      end
      FUNC_DISARM: begin
        armed_nxt          = 1'b0;
        res_nxt.ramp_reset = 1'b1;
      end
      FUNC_LATCH_ESTOP: begin
        estop_nxt          = 1'b1;
        armed_nxt          = 1'b0;
        res_nxt.ramp_reset = 1'b1;
      end
      FUNC_CLEAR_ESTOP: begin
        if (armed_r) begin
          res_nxt.accepted = 1'b0;
        end else begin
          estop_nxt = 1'b0;
        end
      end
      default: begin
        res_nxt.accepted = 1'b0;
      end
    endcase
    res_nxt.brain_mode      = brain_nxt;
    res_nxt.is_armed        = armed_nxt;
    res_nxt.estop_active    = estop_nxt;
    res_nxt.may_enter_brain = !brain_nxt && !armed_nxt && !estop_nxt && cmd.config_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brain_r     <= 1'b0;
      armed_r     <= 1'b0;
      estop_r     <= 1'b0;
      last_r      <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        brain_r <= brain_nxt;
        armed_r <= armed_nxt;
        estop_r <= estop_nxt;
        last_r  <= last_nxt;
      end
      if (cmd_ready) begin
        res_valid_r <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> design/arm_disarm_safety_supervisor.sv
// Channel   Direction  Handshake     Payload
// in_if     input      valid/ready   func, now_time_ms, config_ok
// out_if    output     valid/ready   accepted, intent_class, brain_mode, is_armed,
//                                    estop_active, ramp_reset, may_enter_brain
// cfg (APB) input      psel/penable  hold_stand_timeout_ms @ 0x0, disarm_timeout_ms @ 0x4
//
// Each command produces exactly one result. It is held in the input register, and its
// result is loaded from there into the result register, from which out_if takes it.
// One command is accepted per cycle while results are taken; the single subtract and
// two compares of the staleness check sit between the input and result registers.
// Reset (rst_n low, synchronous) clears mode, armed flag, estop latch and last intent
// time, restores both timeouts, and empties both registers. A stalled result holds the
// result register, the input register holds behind it, and in_if.ready falls only when
// both are full and the result is not being taken, or while in reset.
module arm_disarm_safety_supervisor import adss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  adss_cmd_if.sink              in_if,
  adss_res_if.source            out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Input register: holds one accepted command until the step logic takes it.
  logic cmd_valid_r;
  cmd_t cmd_r;
  logic core_ready;
  logic in_fire;
  thr_t thr;
  logic res_valid;
  res_t res;

  // The input register frees as soon as the step logic consumes its command, so a
  // new command can enter in the same cycle. Nothing is taken while in reset.
  assign in_if.ready = rst_n && (!cmd_valid_r || core_ready);
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (!cmd_valid_r || core_ready) begin
      cmd_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r.func        <= in_if.func;
      cmd_r.now_time_ms <= in_if.now_time_ms;
      cmd_r.config_ok   <= in_if.config_ok;
    end
  end

  // Timeout registers behind the APB port.
  adss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .thr     (thr)
  );

  // Supervisor state, the per-command step and the result register.
  adss_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .thr       (thr),
    .cmd_valid (cmd_valid_r),
    .cmd       (cmd_r),
    .cmd_ready (core_ready),
    .res_valid (res_valid),
    .res_ready (out_if.ready),
    .res       (res)
  );

  assign out_if.valid           = res_valid;
  assign out_if.accepted        = res.accepted;
  assign out_if.intent_class    = res.intent_class;
  assign out_if.brain_mode      = res.brain_mode;
  assign out_if.is_armed        = res.is_armed;
  assign out_if.estop_active    = res.estop_active;
  assign out_if.ramp_reset      = res.ramp_reset;
  assign out_if.may_enter_brain = res.may_enter_brain;

endmodule

>>> design/adss_checker.sv
`include "arm_disarm_safety_supervisor_assert.svh"

module adss_checker import adss_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               accepted,
  input logic [CLASS_W-1:0] intent_class,
  input logic               brain_mode,
  input logic               is_armed,
  input logic               estop_active,
  input logic               ramp_reset,
  input logic               may_enter_brain
);

  res_t res_view;

  assign res_view = {accepted, intent_class, brain_mode, is_armed, estop_active,
                     ramp_reset, may_enter_brain};

  // A stalled result stays on the port unchanged.
  `ADSS_ASSERT_NEXT(a_res_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res_view))

  // The block can only be armed in brain mode and never with the estop latched.
  `ADSS_ASSERT_SAME(a_armed_safe, clk, rst_n, out_valid && is_armed, brain_mode && !estop_active)

  // A disarm-required tick always leaves the block disarmed.
  `ADSS_ASSERT_SAME(a_disarm_req, clk, rst_n, out_valid && intent_class == CLASS_DISARM_REQ, !is_armed && ramp_reset)

  // Brain entry is only offered from a safe, idle mux state; the unused class never shows.
  `ADSS_ASSERT_SAME(a_may_enter, clk, rst_n, out_valid && may_enter_brain, !brain_mode && !is_armed && !estop_active && intent_class != CLASS_UNUSED)

endmodule

bind arm_disarm_safety_supervisor adss_checker u_adss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .accepted        (out_if.accepted),
  .intent_class    (out_if.intent_class),
  .brain_mode      (out_if.brain_mode),
  .is_armed        (out_if.is_armed),
  .estop_active    (out_if.estop_active),
  .ramp_reset      (out_if.ramp_reset),
  .may_enter_brain (out_if.may_enter_brain)
);

>>> tb/adss_checker.sv
module adss_tb_checker import adss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  adss_cmd_if                   cmd,
  adss_res_if                   res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the supervisor state and its two timeouts.
  logic [THR_W-1:0]  hold_ms;
  logic [THR_W-1:0]  disarm_ms;
  logic              mode_brain;
  logic              armed;
  logic              estop_shadow;
  logic [TIME_W-1:0] intent_stamp;

  res_t expected_results[$];
  int   fails;
  int   checked;

  initial begin
    fails = 0;
    checked = 0;
    fail_count = 0;
    pending = 0;
    results_checked = 0;
  end

  // Applies one command to the shadow state and returns the result it must produce.
  function automatic res_t supervise_step(cmd_t c);
    res_t              r;
    logic [TIME_W-1:0] stale;
    r = '0;
    r.accepted = 1'b1;
    r.intent_class = CLASS_FRESH;
    case (c.func)
      FUNC_TICK: begin
        if (estop_shadow) begin
          armed = 1'b0;
          r.ramp_reset = 1'b1;
          r.intent_class = CLASS_DISARM_REQ;
        end else begin
          // Staleness wraps with the time stamp.
          stale = c.now_time_ms[TIME_W-1:0] - intent_stamp;
          if (stale > disarm_ms) begin
            r.intent_class = CLASS_DISARM_REQ;
          end else if (stale > hold_ms) begin
            r.intent_class = CLASS_HOLD_STAND;
          end
          if (r.intent_class == CLASS_DISARM_REQ) begin
            armed = 1'b0;
            r.ramp_reset = 1'b1;
          end else if (r.intent_class == CLASS_HOLD_STAND && armed) begin
            r.ramp_reset = 1'b1;
          end
        end
      end
      FUNC_NOTE_INTENT: intent_stamp = c.now_time_ms[TIME_W-1:0];
      FUNC_ENTER_BRAIN: begin
        if (!mode_brain && !armed && !estop_shadow && c.config_ok) begin
          mode_brain = 1'b1;
          armed = 1'b0;
          r.ramp_reset = 1'b1;
        end else begin
          r.accepted = 1'b0;
        end
      end
      FUNC_ENTER_MUX: begin
        mode_brain = 1'b0;
        armed = 1'b0;
        r.ramp_reset = 1'b1;
      end
      FUNC_ARM: begin
        if (!mode_brain || estop_shadow || !c.config_ok) begin
          armed = 1'b0;
          r.accepted = 1'b0;
        end else begin
          armed = 1'b1;
          intent_stamp = c.now_time_ms[TIME_W-1:0];
          r.ramp_reset = 1'b1;
        end
      end
      FUNC_DISARM: begin
        armed = 1'b0;
        r.ramp_reset = 1'b1;
      end
      FUNC_LATCH_ESTOP: begin
        estop_shadow = 1'b1;
        armed = 1'b0;
        r.ramp_reset = 1'b1;
      end
      FUNC_CLEAR_ESTOP: begin
        if (armed) begin
          r.accepted = 1'b0;
        end else begin
          estop_shadow = 1'b0;
        end
      end
      default: ;
    endcase
    r.brain_mode = mode_brain;
    r.is_armed = armed;
    r.estop_active = estop_shadow;
    r.may_enter_brain = !mode_brain && !armed && !estop_shadow && c.config_ok;
    return r;
  endfunction

  task automatic compare_field(string field, logic [1:0] want_v, logic [1:0] got_v);
    if (got_v !== want_v) begin
      fails++;
      $display("t=%0t result %0d: %s expected %0d actual %0d",
               $time, checked, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    cmd_t                  c;
    res_t                  want;
    logic [CFG_DATA_W-1:0] reg_word;
    if (!rst_n) begin
      hold_ms = HOLD_STAND_DEFAULT_MS;
      disarm_ms = DISARM_DEFAULT_MS;
      mode_brain = 1'b0;
      armed = 1'b0;
      estop_shadow = 1'b0;
      intent_stamp = '0;
      expected_results.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if ((paddr >> CFG_IDX_LSB) == REG_HOLD_STAND) begin
            hold_ms = pwdata[THR_W-1:0];
          end else if ((paddr >> CFG_IDX_LSB) == REG_DISARM) begin
            disarm_ms = pwdata[THR_W-1:0];
          end
        end else begin
          reg_word = '0;
          reg_word[THR_W-1:0] = ((paddr >> CFG_IDX_LSB) == REG_HOLD_STAND) ? hold_ms
                                                                           : disarm_ms;
          if (prdata !== reg_word) begin
            fails++;
            $display("t=%0t register read at 0x%0h: expected 0x%0h actual 0x%0h",
                     $time, paddr, reg_word, prdata);
          end
        end
      end

      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          fails++;
          $display("t=%0t result with no command outstanding: expected none actual %p",
                   $time, res_t'{res.accepted, res.intent_class, res.brain_mode, res.is_armed,
                                 res.estop_active, res.ramp_reset, res.may_enter_brain});
        end else begin
          want = expected_results.pop_front();
          checked++;
          compare_field("accepted", want.accepted, res.accepted);
          compare_field("intent_class", want.intent_class, res.intent_class);
          compare_field("brain_mode", want.brain_mode, res.brain_mode);
          compare_field("is_armed", want.is_armed, res.is_armed);
          compare_field("estop_active", want.estop_active, res.estop_active);
          compare_field("ramp_reset", want.ramp_reset, res.ramp_reset);
          compare_field("may_enter_brain", want.may_enter_brain, res.may_enter_brain);
        end
      end

      if (cmd.valid && cmd.ready) begin
        c.func = cmd.func;
        c.now_time_ms = cmd.now_time_ms;
        c.config_ok = cmd.config_ok;
        expected_results.push_back(supervise_step(c));
      end
    end
    // Published with nonblocking updates so the stimulus side samples settled values.
    pending <= expected_results.size();
    fail_count <= fails;
    results_checked <= checked;
  end

endmodule

>>> tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import adss_pkg::*;

  // Random commands sent under each timeout setting, the default one included.
  localparam int RANDOM_PER_SETTING = 275;
  // Length of the one long receiver stall that backs the block up.
  localparam int HOLD_OFF_CYCLES = 400;
  // Cycles without any handshake or register access before the run is declared hung.
  // The slowest legal stretch is the long stall above; this leaves ample margin.
  localparam int WATCHDOG_CYCLES = 3000;

  typedef enum int {DRAIN_FREE, DRAIN_LIGHT, DRAIN_HEAVY, DRAIN_PERIODIC} drain_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int fail_count;
  int pending;
  int results_checked;

  adss_cmd_if cmd_ch ();
  adss_res_if res_ch ();

  arm_disarm_safety_supervisor dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (cmd_ch),
    .out_if  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The checker watches both channels and the register port, keeps its own copy of
  // the supervisor state and compares every result with its prediction.
  adss_tb_checker supervisor_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd_ch),
    .res             (res_ch),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stimulus bookkeeping. The running time base only shapes the time stamps so that
  // staleness lands around the thresholds; it plays no part in checking.
  int                     burst_left;
  int                     items_sent;
  int                     settings_run;
  logic [NOW_W-1:0]       t_now;
  logic [THR_W-1:0]       hold_cur;
  logic [THR_W-1:0]       disarm_cur;
  logic                   hold_off_req;
  logic                   hold_off_done;
  int                     idle_cycles;

  // Sends one command. Commands go out in bursts of random length; between bursts
  // valid drops for a random gap, and some bursts follow on with no gap at all.
  task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [NOW_W-1:0] now,
                          input logic ok);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.func <= func;
    cmd_ch.now_time_ms <= now;
    cmd_ch.config_ok <= ok;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stops sending and waits until every outstanding result has come back. Each
  // command yields exactly one result, so an empty expectation list means idle.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  // One register transfer: a setup phase, then an access phase, then an idle phase
  // so that back-to-back transfers never drive psel twice in one step. The upper
  // half of the write data is random; only the low 16 bits belong to the register.
  task automatic cfg_access(input logic write, input logic [0:0] idx,
                            input logic [THR_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[THR_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= CFG_ADDR_W'(idx) << CFG_IDX_LSB;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly small forward steps of the time base, scaled to the thresholds in force,
  // with an occasional fully random stamp so that every bit of the field toggles.
  function automatic logic [NOW_W-1:0] next_time(int step_max);
    if ($urandom_range(0, 19) == 0) return NOW_W'($urandom);
    t_now += NOW_W'($urandom_range(0, step_max));
    return t_now;
  endfunction

  // Ticks and intents dominate, as they do in service; the mode and estop commands
  // are frequent enough to move the supervisor through all of its states.
  function automatic logic [FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return FUNC_TICK;
    if (r < 55) return FUNC_NOTE_INTENT;
    if (r < 63) return FUNC_ENTER_BRAIN;
    if (r < 71) return FUNC_ARM;
    if (r < 76) return FUNC_ENTER_MUX;
    if (r < 82) return FUNC_DISARM;
    if (r < 88) return FUNC_LATCH_ESTOP;
    return FUNC_CLEAR_ESTOP;
  endfunction

  task automatic random_phase(input int count);
    int n;
    int step_max;
    step_max = ((hold_cur > disarm_cur) ? int'(hold_cur) : int'(disarm_cur)) / 3 + 2;
    // Start some phases just below the wrap point so staleness crosses zero.
    if ($urandom_range(0, 1) != 0) begin
      t_now = NOW_W'($urandom);
    end else begin
      t_now = NOW_W'(32'hFFFF_FFFF - $urandom_range(0, 50000));
    end
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 99) < 12) begin
        // A well-formed arming session from whatever state the block is in: back to
        // mux, clear the estop, enter brain mode and arm. What follows then runs
        // against an armed supervisor.
        send_cmd(FUNC_ENTER_MUX, next_time(step_max), 1'b1);
        send_cmd(FUNC_CLEAR_ESTOP, next_time(step_max), 1'b1);
        send_cmd(FUNC_ENTER_BRAIN, next_time(step_max), 1'b1);
        send_cmd(FUNC_ARM, next_time(step_max), 1'b1);
        n += 4;
      end else begin
        send_cmd(pick_func(), next_time(step_max), $urandom_range(0, 7) != 0);
        n++;
      end
    end
  endtask

  // Changes both timeouts while the block is idle, reads them back, then runs a
  // random phase under the new setting.
  task automatic run_setting(input logic [THR_W-1:0] hold, input logic [THR_W-1:0] disarm);
    drain_results();
    cfg_access(1'b1, REG_HOLD_STAND, hold);
    cfg_access(1'b1, REG_DISARM, disarm);
    cfg_access(1'b0, REG_HOLD_STAND, '0);
    cfg_access(1'b0, REG_DISARM, '0);
    hold_cur = hold;
    disarm_cur = disarm;
    settings_run++;
    random_phase(RANDOM_PER_SETTING);
  endtask

  // Main stimulus: reset, a directed walk through the special cases, then random
  // phases under a range of timeout settings, extremes included.
  initial begin
    logic [THR_W-1:0] rand_hold;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.func = FUNC_TICK;
    cmd_ch.now_time_ms = '0;
    cmd_ch.config_ok = 1'b0;
    burst_left = 0;
    items_sent = 0;
    settings_run = 1;
    t_now = '0;
    hold_cur = HOLD_STAND_DEFAULT_MS;
    disarm_cur = DISARM_DEFAULT_MS;
    hold_off_req = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // The timeouts must read back as their reset values.
    cfg_access(1'b0, REG_HOLD_STAND, '0);
    cfg_access(1'b0, REG_DISARM, '0);

    // Directed part, under the reset timeouts of 200 ms and 1000 ms. The last
    // intent time starts at zero.
    send_cmd(FUNC_TICK, 32'h0000_0000, 1'b1);         // zero staleness: fresh
    send_cmd(FUNC_TICK, 32'h0000_00C9, 1'b0);         // hold stand while unarmed: no ramp
    send_cmd(FUNC_TICK, 32'h0000_03E9, 1'b1);         // disarm required
    send_cmd(FUNC_ENTER_BRAIN, 32'h0000_0400, 1'b0);  // refused, config not valid
    send_cmd(FUNC_ARM, 32'h0000_0401, 1'b1);          // refused in mux mode
    send_cmd(FUNC_ENTER_BRAIN, 32'h0000_0402, 1'b1);  // accepted
    send_cmd(FUNC_ENTER_BRAIN, 32'h0000_0403, 1'b1);  // refused, already in brain mode
    send_cmd(FUNC_ARM, 32'h0000_0404, 1'b0);          // refused, config not valid
    send_cmd(FUNC_ARM, 32'hFFFF_FF00, 1'b1);          // armed, intent stamped near the wrap
    send_cmd(FUNC_TICK, 32'h0000_0010, 1'b1);         // wrapped staleness 272: hold, ramp
    send_cmd(FUNC_NOTE_INTENT, 32'h0000_0020, 1'b1);
    send_cmd(FUNC_TICK, 32'h0000_00E8, 1'b1);         // exactly the hold timeout: fresh
    send_cmd(FUNC_TICK, 32'h0000_00E9, 1'b1);         // one past it: hold stand
    send_cmd(FUNC_TICK, 32'h0000_0408, 1'b1);         // exactly the disarm timeout: hold
    send_cmd(FUNC_CLEAR_ESTOP, 32'h0000_0408, 1'b1);  // refused while armed
    send_cmd(FUNC_TICK, 32'h0000_0409, 1'b1);         // one past it: forced disarm
    send_cmd(FUNC_LATCH_ESTOP, 32'h0000_0409, 1'b1);
    send_cmd(FUNC_TICK, 32'h0000_0020, 1'b1);         // latched estop overrides fresh intent
    send_cmd(FUNC_ARM, 32'h0000_0021, 1'b1);          // refused under estop
    send_cmd(FUNC_ENTER_MUX, 32'h0000_0022, 1'b1);
    send_cmd(FUNC_ENTER_BRAIN, 32'h0000_0023, 1'b1);  // refused under estop
    send_cmd(FUNC_CLEAR_ESTOP, 32'h0000_0024, 1'b1);  // accepted while unarmed
    send_cmd(FUNC_DISARM, 32'h0000_0025, 1'b0);       // already disarmed, ramp still resets
    send_cmd(FUNC_NOTE_INTENT, 32'hFFFF_FFFF, 1'b1);  // all-ones time stamp
    send_cmd(FUNC_TICK, 32'h0000_0000, 1'b1);         // staleness one across the wrap

    // First random phase runs under the reset timeouts and carries the long
    // receiver stall, so the block fills and must hold off its input.
    hold_off_req = 1'b1;
    random_phase(RANDOM_PER_SETTING);

    run_setting(16'd0, 16'd0);
    run_setting(16'hFFFF, 16'hFFFF);
    run_setting(16'd0, 16'hFFFF);
    run_setting(16'hFFFF, 16'd0);
    rand_hold = THR_W'($urandom_range(0, 3000));
    run_setting(rand_hold, rand_hold + THR_W'($urandom_range(0, 5000)));
    run_setting(HOLD_STAND_DEFAULT_MS, DISARM_DEFAULT_MS);

    drain_results();
    // Idle on afterwards to make sure nothing stray follows.
    repeat (4) @(posedge clk);

    $display("Sent %0d commands and checked %0d results under %0d timeout settings,",
             items_sent, results_checked, settings_run);
    $display("from zero to full scale, with bursty input and a long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: ready follows a stall mode that changes at random intervals, from
  // never stalling to mostly stalling and a fixed one-in-three pattern. Once, on
  // request, it holds off for a long stretch counted here.
  initial begin
    drain_mode_t drain_mode;
    int          mode_left;
    int          hold_left;
    int          beat;
    drain_mode = DRAIN_FREE;
    mode_left = 0;
    hold_left = 0;
    beat = 0;
    hold_off_done = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          drain_mode = drain_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end else begin
          mode_left--;
        end
        case (drain_mode)
          DRAIN_FREE:  res_ch.ready <= 1'b1;
          DRAIN_LIGHT: res_ch.ready <= ($urandom_range(0, 3) != 0);
          DRAIN_HEAVY: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     res_ch.ready <= (beat % 3 == 0);
        endcase
      end
    end
  end

  // Watchdog: any handshake or register access counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
        psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Timed out after %0d cycles without progress, %0d results outstanding.",
               idle_cycles, pending);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> sim.f
+incdir+design
design/adss_pkg.sv
design/adss_if.sv
design/adss_cfg.sv
design/adss_core.sv
design/arm_disarm_safety_supervisor.sv
design/adss_checker.sv
tb/adss_checker.sv
tb/tb.sv
